// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// clocked assertion macros shared by the dma register file modules
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every rising edge, off while reset is asserted
`define DMARF_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("dma register file assertion failed");

// implication form, antecedent then consequent on the next edge
`define DMARF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  `DMARF_ASSERT(label, clk, rst_n, (ante) |=> (cons))

`endif

// ===== hdl/dmarf_pkg.sv =====
// ----------------------------------------------------------------------------
// dmarf_pkg
// types and port codes of the dma controller register file
// ----------------------------------------------------------------------------
package dmarf_pkg;

  localparam int unsigned NumChannels = 4;
  localparam int unsigned ChanW       = $clog2(NumChannels);

  localparam logic ActWrite = 1'b0;
  localparam logic ActRead  = 1'b1;

  localparam logic [7:0] PortRegFileEnd = 8'h08;
  localparam logic [7:0] PortStatus     = 8'h08;
  localparam logic [7:0] PortRequest    = 8'h09;
  localparam logic [7:0] PortSingleMask = 8'h0A;
  localparam logic [7:0] PortMode       = 8'h0B;
  localparam logic [7:0] PortClearFf    = 8'h0C;
  localparam logic [7:0] PortMasterClr  = 8'h0D;
  localparam logic [7:0] PortClearMask  = 8'h0E;
  localparam logic [7:0] PortMultiMask  = 8'h0F;
  localparam logic [7:0] PortPageFirst  = 8'h81;
  localparam logic [7:0] PortPageLast   = 8'h83;

  localparam logic [NumChannels-1:0] MaskAll = '1;

  typedef struct packed {
    logic       action;
    logic [7:0] port;
    logic [7:0] wr_byte;
  } access_t;

endpackage

// ===== hdl/dmarf_regs.sv =====
// ----------------------------------------------------------------------------
// dmarf_regs
// channel, mask, request and status registers; executes one bus word
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dmarf_regs (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              exec_i,
  input  dmarf_pkg::access_t acc_i,
  output logic [7:0]        rd_data_o
);

  localparam int unsigned NCh = dmarf_pkg::NumChannels;
  localparam int unsigned CW  = dmarf_pkg::ChanW;

  logic [23:0]    base_addr_q [NCh];
  logic [23:0]    base_addr_d [NCh];
  logic [15:0]    cur_addr_q [NCh];
  logic [15:0]    cur_addr_d [NCh];
  logic [15:0]    base_count_q [NCh];
  logic [15:0]    base_count_d [NCh];
  logic [15:0]    cur_count_q [NCh];
  logic [15:0]    cur_count_d [NCh];
  logic [7:0]     chan_mode_q [NCh];
  logic [7:0]     chan_mode_d [NCh];
  logic [NCh-1:0] req_q, req_d;
  logic [NCh-1:0] mask_q, mask_d;
  logic [7:0]     status_q, status_d;
  logic           ff_q, ff_d;

  logic [CW-1:0]  ch;
  logic [CW-1:0]  page_ch;
  logic [CW-1:0]  val_ch;
  logic           is_count;
  logic           is_write;
  logic [15:0]    sel_val;

  function automatic logic [NCh-1:0] set_or_clear(logic [NCh-1:0] bits, logic [7:0] val);
    logic [NCh-1:0] one_hot;
    one_hot = '0;
    one_hot[val[CW-1:0]] = 1'b1;
    if (val[2]) begin
      return bits | one_hot;
    end
    return bits & ~one_hot;
  endfunction

  assign ch       = acc_i.port[CW:1];
  assign page_ch  = acc_i.port[CW-1:0];
  assign val_ch   = acc_i.wr_byte[CW-1:0];
  assign is_count = acc_i.port[0];
  assign is_write = (acc_i.action == dmarf_pkg::ActWrite);
  assign sel_val  = is_count ? cur_count_q[ch] : cur_addr_q[ch];

  always_comb begin
    base_addr_d  = base_addr_q;
    cur_addr_d   = cur_addr_q;
    base_count_d = base_count_q;
    cur_count_d  = cur_count_q;
    chan_mode_d  = chan_mode_q;
    req_d        = req_q;
    mask_d       = mask_q;
    status_d     = status_q;
    ff_d         = ff_q;
    rd_data_o    = '0;
    if (exec_i) begin
      if (acc_i.port < dmarf_pkg::PortRegFileEnd) begin
        if (!is_write) begin
          rd_data_o = ff_q ? sel_val[15:8] : sel_val[7:0];
        end else if (is_count) begin
          if (ff_q) begin
            base_count_d[ch][15:8] = acc_i.wr_byte;
            cur_count_d[ch][15:8]  = acc_i.wr_byte;
          end else begin
            base_count_d[ch][7:0] = acc_i.wr_byte;
            cur_count_d[ch][7:0]  = acc_i.wr_byte;
          end
        end else begin
          if (ff_q) begin
            base_addr_d[ch][15:8] = acc_i.wr_byte;
            cur_addr_d[ch][15:8]  = acc_i.wr_byte;
          end else begin
            base_addr_d[ch][7:0] = acc_i.wr_byte;
            cur_addr_d[ch][7:0]  = acc_i.wr_byte;
          end
        end
        ff_d = !ff_q;
      end else if (acc_i.port == dmarf_pkg::PortStatus) begin
        if (!is_write) begin
          status_d  = status_q | {req_q, 4'h0};
          rd_data_o = status_d;
        end
      end else if (acc_i.port >= dmarf_pkg::PortPageFirst &&
                   acc_i.port <= dmarf_pkg::PortPageLast) begin
        if (is_write) begin
          base_addr_d[page_ch][23:16] = acc_i.wr_byte;
        end
      end else if (is_write) begin
        unique case (acc_i.port)
          dmarf_pkg::PortRequest:    req_d = set_or_clear(req_q, acc_i.wr_byte);
          dmarf_pkg::PortSingleMask: mask_d = set_or_clear(mask_q, acc_i.wr_byte);
          dmarf_pkg::PortMode:       chan_mode_d[val_ch] = acc_i.wr_byte;
          dmarf_pkg::PortClearFf:    ff_d = 1'b0;
          dmarf_pkg::PortMasterClr: begin
            ff_d     = 1'b0;
            status_d = '0;
            mask_d   = dmarf_pkg::MaskAll;
          end
          dmarf_pkg::PortClearMask:  mask_d = '0;
          dmarf_pkg::PortMultiMask:  mask_d = acc_i.wr_byte[NCh-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NCh; i++) begin
        base_addr_q[i]  <= '0;
        cur_addr_q[i]   <= '0;
        base_count_q[i] <= '0;
        cur_count_q[i]  <= '0;
        chan_mode_q[i]  <= '0;
      end
      req_q    <= '0;
      mask_q   <= dmarf_pkg::MaskAll;
      status_q <= '0;
      ff_q     <= 1'b0;
    end else begin
      base_addr_q  <= base_addr_d;
      cur_addr_q   <= cur_addr_d;
      base_count_q <= base_count_d;
      cur_count_q  <= cur_count_d;
      chan_mode_q  <= chan_mode_d;
      req_q        <= req_d;
      mask_q       <= mask_d;
      status_q     <= status_d;
      ff_q         <= ff_d;
    end
  end

  // master clear and clear flip-flop always leave low byte next
  `DMARF_ASSERT_NEXT(a_ff_cleared, clk_i, rst_ni,
    exec_i && is_write && (acc_i.port == dmarf_pkg::PortMasterClr ||
    acc_i.port == dmarf_pkg::PortClearFf), !ff_q)
  // a status read leaves the pending requests in the status register
  `DMARF_ASSERT_NEXT(a_status_sticky, clk_i, rst_ni,
    exec_i && !is_write && acc_i.port == dmarf_pkg::PortStatus,
    (status_q[7:4] & $past(req_q)) == $past(req_q))
  // register file words flip the byte pointer
  `DMARF_ASSERT_NEXT(a_ff_toggle, clk_i, rst_ni,
    exec_i && acc_i.port < dmarf_pkg::PortRegFileEnd, ff_q != $past(ff_q))

endmodule

// ===== hdl/dma_controller_register_file_core.sv =====
// ----------------------------------------------------------------------------
// dma_controller_register_file_core
// bus side register file of a four-channel dma controller
// ----------------------------------------------------------------------------
//  channel | signals                                  | direction
//  --------+------------------------------------------+----------
//  in      | in_valid_i, in_stall_o, action_i,        | to block
//          | port_i, wr_byte_i                        |
//  out     | out_valid_o, out_stall_i, rd_byte_o      | from block
//
//  one word accepted per cycle while in_stall_o is low; the read byte is registered on execute
//  the input register feeds one pass of register decode into the result register
//  reset clears all channel state, masks all channels, empties both stages
//  a stalled output holds its byte; the input stalls only when both stages are
//  full and the output is stalled
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dma_controller_register_file_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic       action_i,
  input  logic [7:0] port_i,
  input  logic [7:0] wr_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] rd_byte_o
);

  logic               in_valid_q, in_valid_d;
  dmarf_pkg::access_t acc_q;
  logic               out_valid_q, out_valid_d;
  logic [7:0]         rd_byte_q;
  logic [7:0]         rd_data;
  logic               out_free;
  logic               exec;
  logic               in_accept;

  assign out_free    = !out_valid_q || !out_stall_i;
  assign exec        = in_valid_q && out_free;
  assign in_stall_o  = in_valid_q && !out_free;
  assign in_accept   = in_valid_i && !in_stall_o;
  assign in_valid_d  = in_accept || (in_valid_q && !exec);
  assign out_valid_d = exec || (out_valid_q && out_stall_i);

  dmarf_regs u_regs (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .exec_i    (exec),
    .acc_i     (acc_q),
    .rd_data_o (rd_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      acc_q <= '{action: action_i, port: port_i, wr_byte: wr_byte_i};
    end
    if (exec) begin
      rd_byte_q <= rd_data;
    end
  end

  assign out_valid_o = out_valid_q;
  assign rd_byte_o   = rd_byte_q;

  // a word in the input register is never dropped
  `DMARF_ASSERT_NEXT(a_hold_word, clk_i, rst_ni, in_valid_q && !exec, in_valid_q)
  // executing a word always produces a result
  `DMARF_ASSERT_NEXT(a_exec_result, clk_i, rst_ni, exec, out_valid_o)
  // writes read back zero
  `DMARF_ASSERT_NEXT(a_write_zero, clk_i, rst_ni,
    exec && acc_q.action == dmarf_pkg::ActWrite, rd_byte_o == 8'h00)

endmodule
